### rtl/dlt_pkg.sv
// ----------------------------------------------------------------------------
// dlt_pkg
// Shared types and constants of the lease table.
// ----------------------------------------------------------------------------
`default_nettype none
package dlt_pkg;
  localparam int NUM_BLOCKS       = 8;
  localparam int LEASES_PER_BLOCK = 32;
  localparam int TABLE_SIZE       = NUM_BLOCKS * LEASES_PER_BLOCK;
  localparam int IDX_W            = $clog2(LEASES_PER_BLOCK);
  localparam int BLK_W            = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SLOT_W           = $clog2(TABLE_SIZE);
  localparam int NB_W             = $clog2(NUM_BLOCKS + 1);
  localparam int CNT_W            = $clog2(LEASES_PER_BLOCK + 2);
  localparam int MASK_W           = 8;

  localparam logic [2:0] K_DISCOVER = 3'd0;
  localparam logic [2:0] K_REQ_ADDR = 3'd1;
  localparam logic [2:0] K_REQ_XID  = 3'd2;
  localparam logic [2:0] K_RELEASE  = 3'd3;
  localparam logic [2:0] K_RENEW    = 3'd4;
  localparam logic [2:0] K_SWEEP    = 3'd5;

  localparam logic [3:0] V_OFFER    = 4'd0;
  localparam logic [3:0] V_ACK      = 4'd1;
  localparam logic [3:0] V_NAK      = 4'd2;
  localparam logic [3:0] V_FORWARD  = 4'd3;
  localparam logic [3:0] V_NOFREE   = 4'd4;
  localparam logic [3:0] V_RELEASED = 4'd5;
  localparam logic [3:0] V_IGNORED  = 4'd6;
  localparam logic [3:0] V_RANGE    = 4'd7;
  localparam logic [3:0] V_SWEPT    = 4'd8;

  localparam logic [2:0] R_BASE    = 3'd0;
  localparam logic [2:0] R_BLOCKS  = 3'd1;
  localparam logic [2:0] R_OWNED   = 3'd2;
  localparam logic [2:0] R_CLAIMED = 3'd3;
  localparam logic [2:0] R_OFFER   = 3'd4;
  localparam logic [2:0] R_LEASE   = 3'd5;
  localparam logic [2:0] R_DELTA   = 3'd6;

  typedef enum logic [1:0] {LS_FREE, LS_OFFERED, LS_LEASED} lease_st_t;

  typedef struct packed {
    lease_st_t   status;
    logic [31:0] xid;
    logic [47:0] hw;
    logic [31:0] end_time;
  } entry_t;

  typedef struct packed {
    logic [31:0]     base_address;
    logic [3:0]      blocks_in_use;
    logic [MASK_W-1:0] owned_mask;
    logic [MASK_W-1:0] claimed_mask;
    logic [15:0]     offer_timeout;
    logic [15:0]     lease_time;
    logic [15:0]     server_delta;
  } cfg_t;

  typedef struct packed {
    logic [3:0]       verdict;
    logic [31:0]      lease_address;
    logic [2:0]       lease_block;
    logic [5:0]       free_count;
  } result_t;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SETUP, S_SCAN, S_DONE} eng_st_t;

  function automatic logic blk_in_mask(logic [BLK_W-1:0] b, logic [MASK_W-1:0] m);
    return (32'(b) < 32'(MASK_W)) && m[3'(b)];
  endfunction
endpackage
`default_nettype wire

### rtl/dlt_if.sv
// ----------------------------------------------------------------------------
// dlt_req_if / dlt_rsp_if
// Valid/ready channels for event words and result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface dlt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] address;
  logic [31:0] xid;
  logic [47:0] client_hw;
  logic [31:0] now_seconds;
  logic [2:0]  sweep_block;
  modport source (output valid, kind, address, xid, client_hw, now_seconds, sweep_block,
                  input ready);
  modport sink (input valid, kind, address, xid, client_hw, now_seconds, sweep_block,
                output ready);
endinterface

interface dlt_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [31:0] lease_address;
  logic [2:0]  lease_block;
  logic [5:0]  free_count;
  modport source (output valid, verdict, lease_address, lease_block, free_count,
                  input ready);
  modport sink (input valid, verdict, lease_address, lease_block, free_count,
                output ready);
endinterface
`default_nettype wire

### rtl/dlt_ram.sv
// ----------------------------------------------------------------------------
// dlt_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module dlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/dlt_engine.sv
// ----------------------------------------------------------------------------
// dlt_engine
// Sequencer: clears the table, scans entries, decides each event and writes back changed entries.
// ----------------------------------------------------------------------------
`default_nettype none
module dlt_engine import dlt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [31:0] in_address,
  input  wire logic [31:0] in_xid,
  input  wire logic [47:0] in_hw,
  input  wire logic [31:0] in_now,
  input  wire logic [2:0]  in_sweep,
  input  wire logic        out_free,
  output logic             push,
  output result_t          result
);
  eng_st_t state, state_next;

  logic [2:0]  kind;
  logic [31:0] address, xid, now;
  logic [47:0] hw;
  logic [2:0]  sweep;
  logic [31:0] gend;
  logic [SLOT_W-1:0] start;
  logic [SLOT_W:0]   total, ptr, clr;
  logic              rd_vld;
  logic [SLOT_W-1:0] rd_slot;
  logic [CNT_W-1:0]  bcnt, best;
  logic [IDX_W-1:0]  bfirst;
  logic [SLOT_W-1:0] bslot;
  logic              found;
  entry_t            ent;

  logic              we;
  logic [SLOT_W-1:0] waddr, raddr;
  entry_t            wdata, rdata;

  logic [NB_W-1:0]   nb;
  logic [31:0]       off;
  logic              in_pool;
  logic              issue;
  logic [BLK_W-1:0]  r_blk;
  logic [IDX_W-1:0]  r_idx;
  logic              r_free, r_exp, r_cnt_hit;
  logic [CNT_W-1:0]  cnt_cur, cnt_new;
  logic [IDX_W-1:0]  first_new;
  logic [BLK_W-1:0]  d_blk;
  logic              d_owned, d_claimed, mine;

  dlt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_SIZE)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign nb = (32'(cfg.blocks_in_use) < 32'(NUM_BLOCKS)) ? NB_W'(cfg.blocks_in_use)
                                                        : NB_W'(NUM_BLOCKS);
  assign off     = address - cfg.base_address;
  assign in_pool = (off >> IDX_W) < 32'(nb);
  assign issue   = (state == S_SCAN) && (ptr < total);
  assign raddr   = start + ptr[SLOT_W-1:0];

  assign r_blk     = BLK_W'(rd_slot >> IDX_W);
  assign r_idx     = rd_slot[IDX_W-1:0];
  assign r_free    = rdata.status == LS_FREE;
  assign r_exp     = !r_free && (rdata.end_time < now);
  assign r_cnt_hit = (kind == K_SWEEP) ? (r_free || r_exp) : r_free;
  assign cnt_cur   = (r_idx == '0) ? '0 : bcnt;
  assign cnt_new   = cnt_cur + CNT_W'(r_cnt_hit);
  assign first_new = (r_free && cnt_cur == '0) ? r_idx : bfirst;

  assign d_blk     = BLK_W'(start >> IDX_W);
  assign d_owned   = blk_in_mask(d_blk, cfg.owned_mask);
  assign d_claimed = !d_owned && blk_in_mask(d_blk, cfg.claimed_mask);
  assign mine      = (ent.status == LS_OFFERED) && (ent.xid == xid);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr == (SLOT_W+1)'(TABLE_SIZE - 1)) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_SETUP;
      S_SETUP: state_next = S_SCAN;
      S_SCAN:  if (!issue && !rd_vld) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state == S_IDLE;
    we       = 1'b0;
    waddr    = start;
    wdata    = ent;
    push     = 1'b0;
    result   = '0;
    result.verdict = V_IGNORED;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr[SLOT_W-1:0];
        wdata = '0;
      end
      S_SCAN: begin
        if (rd_vld && kind == K_SWEEP && r_exp) begin
          we    = 1'b1;
          waddr = rd_slot;
          wdata = '{status: LS_FREE, xid: '0, hw: '0, end_time: rdata.end_time};
        end
      end
      S_DONE: begin
        push = out_free;
        case (kind)
          K_DISCOVER: begin
            if (found) begin
              we    = out_free;
              waddr = bslot;
              wdata = '{status: LS_OFFERED, xid: xid, hw: hw,
                        end_time: now + 32'(cfg.offer_timeout)};
              result.verdict       = V_OFFER;
              result.lease_address = cfg.base_address + 32'(bslot);
              result.lease_block   = 3'(bslot >> IDX_W);
            end else begin
              result.verdict = V_NOFREE;
            end
          end
          K_REQ_ADDR: begin
            if (total == '0) begin
              result.verdict = V_NAK;
            end else if (d_claimed || (d_owned &&
                         (mine || hw == ent.hw || ent.status == LS_FREE))) begin
              we    = out_free;
              wdata = '{status: d_claimed ? LS_OFFERED : LS_LEASED, xid: xid, hw: hw,
                        end_time: gend};
              result.verdict       = d_claimed ? V_FORWARD : V_ACK;
              result.lease_address = cfg.base_address + 32'(start);
              result.lease_block   = 3'(d_blk);
            end else if (d_owned) begin
              result.verdict = V_NAK;
            end
          end
          K_REQ_XID: begin
            if (found) begin
              we    = out_free;
              waddr = bslot;
              wdata = '{status: LS_LEASED, xid: xid, hw: hw, end_time: gend};
              result.verdict       = V_ACK;
              result.lease_address = cfg.base_address + 32'(bslot);
              result.lease_block   = 3'(bslot >> IDX_W);
            end else begin
              result.verdict = V_NAK;
            end
          end
          K_RELEASE: begin
            if (total == '0) begin
              result.verdict = V_RANGE;
            end else if (d_owned && ent.hw == hw) begin
              we    = out_free;
              wdata = '{status: LS_FREE, xid: '0, hw: '0, end_time: ent.end_time};
              result.verdict = V_RELEASED;
            end
          end
          K_RENEW: begin
            if (total == '0) begin
              result.verdict = V_RANGE;
            end else if (d_owned) begin
              we    = out_free;
              wdata = '{status: ent.status, xid: ent.xid, hw: ent.hw, end_time: gend};
              result.verdict       = V_ACK;
              result.lease_address = cfg.base_address + 32'(start);
              result.lease_block   = 3'(d_blk);
            end else begin
              result.verdict = V_NAK;
            end
          end
          K_SWEEP: begin
            if (total == '0) begin
              result.verdict = V_RANGE;
            end else begin
              result.verdict     = V_SWEPT;
              result.lease_block = sweep;
              result.free_count  = 6'(bcnt);
            end
          end
          default: result.verdict = V_IGNORED;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      clr    <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (state == S_CLEAR) clr <= clr + 1'b1;
    end
    rd_slot <= raddr;
    if (issue) ptr <= ptr + 1'b1;
    if (state == S_IDLE && in_valid) begin
      kind    <= in_kind;
      address <= in_address;
      xid     <= in_xid;
      hw      <= in_hw;
      now     <= in_now;
      sweep   <= in_sweep;
    end
    if (state == S_SETUP) begin
      gend  <= now + 32'(cfg.lease_time) + 32'(cfg.server_delta);
      ptr   <= '0;
      found <= 1'b0;
      best  <= CNT_W'(LEASES_PER_BLOCK + 1);
      bcnt  <= '0;
      case (kind)
        K_DISCOVER, K_REQ_XID: begin
          start <= '0;
          total <= (SLOT_W+1)'(nb) << IDX_W;
        end
        K_REQ_ADDR, K_RELEASE, K_RENEW: begin
          start <= off[SLOT_W-1:0];
          total <= (SLOT_W+1)'(in_pool);
        end
        K_SWEEP: begin
          start <= SLOT_W'(BLK_W'(sweep)) << IDX_W;
          total <= (32'(sweep) < 32'(nb)) ? (SLOT_W+1)'(LEASES_PER_BLOCK) : '0;
        end
        default: begin
          start <= '0;
          total <= '0;
        end
      endcase
    end
    if (rd_vld) begin
      ent    <= rdata;
      bcnt   <= cnt_new;
      bfirst <= first_new;
      if (kind == K_DISCOVER && r_idx == IDX_W'(LEASES_PER_BLOCK - 1) &&
          blk_in_mask(r_blk, cfg.owned_mask) && cnt_new != '0 && cnt_new < best) begin
        best  <= cnt_new;
        bslot <= SLOT_W'({r_blk, first_new});
        found <= 1'b1;
      end
      if (kind == K_REQ_XID && !found && blk_in_mask(r_blk, cfg.owned_mask) &&
          rdata.status == LS_OFFERED && rdata.xid == xid && rdata.hw == hw) begin
        bslot <= rd_slot;
        found <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/dhcp_lease_table_core.sv
// ----------------------------------------------------------------------------
// dhcp_lease_table_core
// Lease table of a block-split DHCP address pool.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one event word (discover, request by address or by xid,
//   release, peer renew, timeout sweep); rsp returns exactly one result word
//   per event. Both are valid/ready channels. Registers are written through
//   cfg_we/cfg_index/cfg_data; the user must write them only while no event
//   is in flight, as the block does not enforce it. The table lives in one
//   RAM with a registered read. Each event goes through setup, a read scan,
//   and a decide/write-back state. A discover or request by xid reads every
//   entry of the configured blocks; a sweep reads one block; other events
//   read a single entry. Entries are read one at a time through the single
//   RAM read port. One event is handled at a time. After reset a clearing
//   pass writes all 256 entries, during which req.ready stays low. Registers
//   return to their reset values. rsp has an output register: the next event
//   is taken while a result waits; a finished event holds in its decide/write-back
//   state until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none
module dhcp_lease_table_core import dlt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  dlt_req_if.sink          req,
  dlt_rsp_if.source        rsp,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  cfg_t    cfg;
  logic    out_free, push;
  result_t result;
  logic    out_valid;
  result_t out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address  <= '0;
      cfg.blocks_in_use <= 4'd8;
      cfg.owned_mask    <= '0;
      cfg.claimed_mask  <= '0;
      cfg.offer_timeout <= 16'd12;
      cfg.lease_time    <= 16'd3600;
      cfg.server_delta  <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        R_BASE:    cfg.base_address  <= cfg_data;
        R_BLOCKS:  cfg.blocks_in_use <= cfg_data[3:0];
        R_OWNED:   cfg.owned_mask    <= cfg_data[MASK_W-1:0];
        R_CLAIMED: cfg.claimed_mask  <= cfg_data[MASK_W-1:0];
        R_OFFER:   cfg.offer_timeout <= cfg_data[15:0];
        R_LEASE:   cfg.lease_time    <= cfg_data[15:0];
        R_DELTA:   cfg.server_delta  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  dlt_engine u_engine (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(req.valid), .in_ready(req.ready),
    .in_kind(req.kind), .in_address(req.address), .in_xid(req.xid),
    .in_hw(req.client_hw), .in_now(req.now_seconds), .in_sweep(req.sweep_block),
    .out_free(out_free), .push(push), .result(result)
  );

  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (push) out_word <= result;
  end

  assign rsp.valid         = out_valid;
  assign rsp.verdict       = out_word.verdict;
  assign rsp.lease_address = out_word.lease_address;
  assign rsp.lease_block   = out_word.lease_block;
  assign rsp.free_count    = out_word.free_count;
endmodule
`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dhcp_lease_table_core. A scoreboard class keeps its
// own copy of the lease table and the registers, predicts one result word for
// every accepted event word and compares the result words in order. Phases
// with different register settings and idle patterns are run in turn.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import dlt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [31:0] xid;
    logic [47:0] hw;
    logic [31:0] now;
    logic [2:0]  sweep_block;
  } event_t;

  class lease_scoreboard;
    cfg_t        cfg;
    lease_st_t   st [TABLE_SIZE];
    logic [31:0] xids [TABLE_SIZE];
    logic [47:0] hws [TABLE_SIZE];
    logic [31:0] ends [TABLE_SIZE];
    result_t     pending [$];
    int          errors;
    int          checked;

    function new();
      cfg.base_address  = 32'd0;
      cfg.blocks_in_use = 4'd8;
      cfg.owned_mask    = 8'd0;
      cfg.claimed_mask  = 8'd0;
      cfg.offer_timeout = 16'd12;
      cfg.lease_time    = 16'd3600;
      cfg.server_delta  = 16'd100;
      for (int s = 0; s < TABLE_SIZE; s++) begin
        st[s] = LS_FREE;
        xids[s] = '0;
        hws[s] = '0;
        ends[s] = '0;
      end
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        R_BASE:    cfg.base_address  = d;
        R_BLOCKS:  cfg.blocks_in_use = d[3:0];
        R_OWNED:   cfg.owned_mask    = d[7:0];
        R_CLAIMED: cfg.claimed_mask  = d[7:0];
        R_OFFER:   cfg.offer_timeout = d[15:0];
        R_LEASE:   cfg.lease_time    = d[15:0];
        R_DELTA:   cfg.server_delta  = d[15:0];
        default: ;
      endcase
    endfunction

    function int eff_blocks();
      return (int'(cfg.blocks_in_use) < NUM_BLOCKS) ? int'(cfg.blocks_in_use) : NUM_BLOCKS;
    endfunction

    function bit is_owned(int b);
      return b < 8 && cfg.owned_mask[b];
    endfunction

    function bit is_claimed(int b);
      return b < 8 && !cfg.owned_mask[b] && cfg.claimed_mask[b];
    endfunction

    function logic [31:0] addr_of(int b, int i);
      return cfg.base_address + 32'(b * LEASES_PER_BLOCK + i);
    endfunction

    function logic [31:0] grant_end(logic [31:0] now);
      return now + 32'(cfg.lease_time) + 32'(cfg.server_delta);
    endfunction

    function void free_slot(int s);
      st[s] = LS_FREE;
      xids[s] = '0;
      hws[s] = '0;
    endfunction

    function void grant(int s, event_t e);
      st[s] = LS_LEASED;
      xids[s] = e.xid;
      hws[s] = e.hw;
      ends[s] = grant_end(e.now);
    endfunction

    function bit in_pool(logic [31:0] a, output int b, output int i);
      logic [31:0] off;
      logic [31:0] blk;
      off = a - cfg.base_address;
      blk = off / LEASES_PER_BLOCK;
      i = int'(off % LEASES_PER_BLOCK);
      b = (blk < 32'(NUM_BLOCKS)) ? int'(blk) : NUM_BLOCKS;
      return blk < 32'(eff_blocks());
    endfunction

    function result_t note_event(event_t e);
      result_t r;
      int nb, b, i, s, best, bb, bi, cnt, first;
      bit found, mine;
      r = '{verdict: V_IGNORED, lease_address: '0, lease_block: '0, free_count: '0};
      nb = eff_blocks();
      case (e.kind)
        K_DISCOVER: begin
          best = LEASES_PER_BLOCK + 1;
          found = 0;
          bb = 0;
          bi = 0;
          for (b = 0; b < nb; b++) begin
            if (!is_owned(b)) continue;
            cnt = 0;
            first = -1;
            for (i = 0; i < LEASES_PER_BLOCK; i++)
              if (st[b * LEASES_PER_BLOCK + i] == LS_FREE) begin
                if (first < 0) first = i;
                cnt++;
              end
            if (cnt > 0 && cnt < best) begin
              best = cnt;
              bb = b;
              bi = first;
              found = 1;
            end
          end
          if (!found) begin
            r.verdict = V_NOFREE;
          end else begin
            s = bb * LEASES_PER_BLOCK + bi;
            st[s] = LS_OFFERED;
            xids[s] = e.xid;
            hws[s] = e.hw;
            ends[s] = e.now + 32'(cfg.offer_timeout);
            r.verdict = V_OFFER;
            r.lease_block = 3'(bb);
            r.lease_address = addr_of(bb, bi);
          end
        end
        K_REQ_ADDR: begin
          if (!in_pool(e.address, b, i)) begin
            r.verdict = V_NAK;
          end else begin
            s = b * LEASES_PER_BLOCK + i;
            if (is_claimed(b)) begin
              st[s] = LS_OFFERED;
              xids[s] = e.xid;
              hws[s] = e.hw;
              ends[s] = grant_end(e.now);
              r.verdict = V_FORWARD;
              r.lease_block = 3'(b);
              r.lease_address = addr_of(b, i);
            end else if (is_owned(b)) begin
              mine = st[s] == LS_OFFERED && xids[s] == e.xid;
              if (!mine && e.hw != hws[s] && st[s] != LS_FREE) begin
                r.verdict = V_NAK;
              end else begin
                grant(s, e);
                r.verdict = V_ACK;
                r.lease_block = 3'(b);
                r.lease_address = addr_of(b, i);
              end
            end
          end
        end
        K_REQ_XID: begin
          r.verdict = V_NAK;
          found = 0;
          for (b = 0; b < nb && !found; b++) begin
            if (!is_owned(b)) continue;
            for (i = 0; i < LEASES_PER_BLOCK && !found; i++) begin
              s = b * LEASES_PER_BLOCK + i;
              if (st[s] == LS_OFFERED && xids[s] == e.xid && hws[s] == e.hw) begin
                grant(s, e);
                r.verdict = V_ACK;
                r.lease_block = 3'(b);
                r.lease_address = addr_of(b, i);
                found = 1;
              end
            end
          end
        end
        K_RELEASE: begin
          if (!in_pool(e.address, b, i)) begin
            r.verdict = V_RANGE;
          end else if (is_owned(b) && hws[b * LEASES_PER_BLOCK + i] == e.hw) begin
            free_slot(b * LEASES_PER_BLOCK + i);
            r.verdict = V_RELEASED;
          end
        end
        K_RENEW: begin
          if (!in_pool(e.address, b, i)) begin
            r.verdict = V_RANGE;
          end else if (is_owned(b)) begin
            ends[b * LEASES_PER_BLOCK + i] = grant_end(e.now);
            r.verdict = V_ACK;
            r.lease_block = 3'(b);
            r.lease_address = addr_of(b, i);
          end else begin
            r.verdict = V_NAK;
          end
        end
        K_SWEEP: begin
          if (int'(e.sweep_block) >= nb) begin
            r.verdict = V_RANGE;
          end else begin
            cnt = 0;
            for (i = 0; i < LEASES_PER_BLOCK; i++) begin
              s = int'(e.sweep_block) * LEASES_PER_BLOCK + i;
              if (st[s] != LS_FREE && ends[s] < e.now) free_slot(s);
              if (st[s] == LS_FREE) cnt++;
            end
            r.verdict = V_SWEPT;
            r.lease_block = e.sweep_block;
            r.free_count = (cnt > 63) ? 6'd63 : 6'(cnt);
          end
        end
        default: ;
      endcase
      pending.push_back(r);
      return r;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word verdict=%0d addr=%h blk=%0d free=%0d",
                 $time, got.verdict, got.lease_address, got.lease_block, got.free_count);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.verdict !== want.verdict) begin
        $display("%0t: verdict expected %0d actual %0d", $time, want.verdict, got.verdict);
        errors++;
      end
      if (got.lease_address !== want.lease_address) begin
        $display("%0t: lease_address expected %h actual %h", $time,
                 want.lease_address, got.lease_address);
        errors++;
      end
      if (got.lease_block !== want.lease_block) begin
        $display("%0t: lease_block expected %0d actual %0d", $time,
                 want.lease_block, got.lease_block);
        errors++;
      end
      if (got.free_count !== want.free_count) begin
        $display("%0t: free_count expected %0d actual %0d", $time,
                 want.free_count, got.free_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  dlt_req_if req_ch();
  dlt_rsp_if rsp_ch();

  dhcp_lease_table_core uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lease_scoreboard table_sb;
  int          gap_pct;
  int          stall_pct;
  int          hold_req;
  int          hold_left;
  int          sent;
  logic [31:0] clock_now;
  event_t      offers [$];

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready && !rst)
      table_sb.check_result('{verdict: rsp_ch.verdict, lease_address: rsp_ch.lease_address,
                              lease_block: rsp_ch.lease_block,
                              free_count: rsp_ch.free_count});
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    table_sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (table_sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] base, logic [3:0] blocks, logic [7:0] owned,
                            logic [7:0] claimed, logic [15:0] ot, logic [15:0] lt,
                            logic [15:0] sd);
    wait_drained();
    repeat (10) @(posedge clk);
    @(posedge clk);
    write_reg(R_BASE, base);
    write_reg(R_BLOCKS, 32'(blocks));
    write_reg(R_OWNED, 32'(owned));
    write_reg(R_CLAIMED, 32'(claimed));
    write_reg(R_OFFER, 32'(ot));
    write_reg(R_LEASE, 32'(lt));
    write_reg(R_DELTA, 32'(sd));
    cfg_we <= 1'b0;
    offers.delete();
  endtask

  task automatic send_event(event_t e);
    result_t r;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= e.kind;
    req_ch.address <= e.address;
    req_ch.xid <= e.xid;
    req_ch.client_hw <= e.hw;
    req_ch.now_seconds <= e.now;
    req_ch.sweep_block <= e.sweep_block;
    do @(posedge clk); while (!req_ch.ready);
    r = table_sb.note_event(e);
    sent++;
    if (r.verdict == V_OFFER) begin
      e.address = r.lease_address;
      offers.push_back(e);
      if (offers.size() > 24) void'(offers.pop_front());
    end
  endtask

  function automatic event_t mk(logic [2:0] k, logic [31:0] a, logic [31:0] x,
                                logic [47:0] h, logic [31:0] n, logic [2:0] sb);
    event_t e;
    e.kind = k;
    e.address = a;
    e.xid = x;
    e.hw = h;
    e.now = n;
    e.sweep_block = sb;
    return e;
  endfunction

  function automatic event_t random_event();
    event_t e;
    event_t o;
    int sel;
    int span;
    sel = $urandom_range(99);
    span = table_sb.eff_blocks() * LEASES_PER_BLOCK;
    if ($urandom_range(49) == 0) clock_now = $urandom();
    else clock_now = clock_now + $urandom_range(0, 6);
    e = mk(K_DISCOVER, table_sb.cfg.base_address + $urandom_range(0, span + 40),
           $urandom(), 48'({$urandom(), $urandom()}), clock_now, 3'($urandom_range(7)));
    if ($urandom_range(3) != 0) e.hw = 48'($urandom_range(15));
    if ($urandom_range(3) != 0) e.xid = $urandom_range(15);
    if (offers.size() > 0) o = offers[$urandom_range(offers.size() - 1)];
    if (sel < 28) begin
      e.kind = K_DISCOVER;
    end else if (sel < 48) begin
      e.kind = K_REQ_XID;
      if (offers.size() > 0 && $urandom_range(4) != 0) begin
        e.xid = o.xid;
        e.hw = o.hw;
      end
    end else if (sel < 63) begin
      e.kind = K_REQ_ADDR;
      if (offers.size() > 0 && $urandom_range(2) != 0) begin
        e.address = o.address;
        if ($urandom_range(1)) e.xid = o.xid;
        if ($urandom_range(1)) e.hw = o.hw;
      end
    end else if (sel < 75) begin
      e.kind = K_RELEASE;
      if (offers.size() > 0 && $urandom_range(2) != 0) begin
        e.address = o.address;
        e.hw = o.hw;
      end
    end else if (sel < 84) begin
      e.kind = K_RENEW;
    end else if (sel < 95) begin
      e.kind = K_SWEEP;
    end else if (sel < 97) begin
      e.kind = 3'($urandom_range(6, 7));
    end else begin
      e.kind = 3'($urandom_range(7));
      e.address = $urandom();
    end
    return e;
  endfunction

  task automatic run_random(int count, int phase, int pressure);
    int base_gap;
    int base_stall;
    case (phase % 4)
      0: begin base_gap = 0;  base_stall = 0;  end
      1: begin base_gap = 48; base_stall = 0;  end
      2: begin base_gap = 0;  base_stall = 48; end
      default: begin base_gap = 30; base_stall = 30; end
    endcase
    for (int n = 0; n < count; n++) begin
      if (n % 60 < 15) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = base_gap;
        stall_pct = base_stall;
      end
      if (pressure == 1 && n == 100) hold_req = 1500;
      if (pressure == 2 && n == 100) begin
        req_ch.valid <= 1'b0;
        wait_drained();
        @(posedge clk);
      end
      send_event(random_event());
    end
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] b0;
    event_t dir [$];
    int wait_cycles;
    table_sb = new();
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    sent = 0;
    clock_now = 32'd1000;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.kind = '0;
    req_ch.address = '0;
    req_ch.xid = '0;
    req_ch.client_hw = '0;
    req_ch.now_seconds = '0;
    req_ch.sweep_block = '0;
    rsp_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (!req_ch.ready) @(posedge clk);

    b0 = 32'h0A00_0000;
    set_config(b0, 4'd8, 8'h0F, 8'h30, 16'd12, 16'd3600, 16'd100);
    dir.push_back(mk(K_DISCOVER, 0, 32'd0, 48'd0, 32'd0, 3'd0));
    dir.push_back(mk(K_DISCOVER, 0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 3'd7));
    dir.push_back(mk(K_REQ_XID, 0, 32'd0, 48'd0, 32'd5, 3'd0));
    dir.push_back(mk(K_REQ_XID, 0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd6, 3'd0));
    dir.push_back(mk(K_REQ_XID, 0, 32'd1, 48'd1, 32'd6, 3'd0));
    dir.push_back(mk(K_REQ_ADDR, b0 + 4 * 32 + 3, 32'd9, 48'd9, 32'd7, 3'd0));
    dir.push_back(mk(K_REQ_ADDR, b0 + 6 * 32, 32'd9, 48'd9, 32'd7, 3'd0));
    dir.push_back(mk(K_REQ_ADDR, b0 - 1, 32'd9, 48'd9, 32'd7, 3'd0));
    dir.push_back(mk(K_REQ_ADDR, b0 + 1, 32'd3, 48'd5, 32'd7, 3'd0));
    dir.push_back(mk(K_REQ_ADDR, b0 + 2, 32'd3, 48'd5, 32'd7, 3'd0));
    dir.push_back(mk(K_RELEASE, b0 + 2, 32'd0, 48'd6, 32'd8, 3'd0));
    dir.push_back(mk(K_RELEASE, b0 + 2, 32'd0, 48'd5, 32'd8, 3'd0));
    dir.push_back(mk(K_RELEASE, b0 + 4 * 32, 32'd0, 48'd0, 32'd8, 3'd0));
    dir.push_back(mk(K_RELEASE, b0 + 256, 32'd0, 48'd0, 32'd8, 3'd0));
    dir.push_back(mk(K_RENEW, b0, 32'd0, 48'd0, 32'd9, 3'd0));
    dir.push_back(mk(K_RENEW, b0 + 5 * 32, 32'd0, 48'd0, 32'd9, 3'd0));
    dir.push_back(mk(K_RENEW, 32'd0, 32'd0, 48'd0, 32'd9, 3'd0));
    dir.push_back(mk(K_DISCOVER, 0, 32'd4, 48'd4, 32'd10, 3'd0));
    dir.push_back(mk(K_SWEEP, 0, 32'd0, 48'd0, 32'hFFFF_FFFF, 3'd0));
    dir.push_back(mk(K_SWEEP, 0, 32'd0, 48'd0, 32'd10, 3'd7));
    dir.push_back(mk(K_SWEEP, 0, 32'd0, 48'd0, 32'd10, 3'd4));
    dir.push_back(mk(3'd6, 32'hFFFF_FFFF, 32'd0, 48'd0, 32'd0, 3'd0));
    dir.push_back(mk(3'd7, 32'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd0, 3'd7));
    foreach (dir[k]) send_event(dir[k]);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    run_random(250, 0, 0);

    set_config(32'hFFFF_FFF0, 4'd8, 8'hFF, 8'h00, 16'd0, 16'd0, 16'd0);
    run_random(260, 1, 0);
    set_config($urandom(), 4'd3, 8'h05, 8'h02, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(260, 2, 1);
    set_config(32'd0, 4'd1, 8'h01, 8'h00, 16'd5, 16'd20, 16'd3);
    run_random(260, 3, 2);
    set_config($urandom(), 4'd15, 8'hAA, 8'h55, 16'd30, 16'd100, 16'd0);
    run_random(260, 0, 0);
    set_config(32'd0, 4'd0, 8'hFF, 8'hFF, 16'd1, 16'd1, 16'd1);
    run_random(40, 1, 0);
    set_config($urandom(), 4'd8, 8'h00, 8'hFF, 16'd9, 16'd50, 16'd2);
    run_random(260, 2, 0);
    set_config(32'hFFFF_FFFF, 4'd8, 8'hFF, 8'hFF, 16'd7, 16'd60, 16'd1);
    run_random(260, 3, 0);

    wait_cycles = 0;
    while (table_sb.pending.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (300) @(posedge clk);
    $display("Sent %0d event words over 8 register settings; %0d result words compared.",
             sent, table_sb.checked);
    if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", table_sb.errors,
               table_sb.pending.size());
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
rtl/dlt_pkg.sv
rtl/dlt_if.sv
rtl/dlt_ram.sv
rtl/dlt_engine.sv
rtl/dhcp_lease_table_core.sv
bench/tb.sv
